FILE: src/utf8_stream_decoder_assert.svh
// Assertion macros for the UTF-8 stream decoder.
// Used inside the top level; expects signals named clock and reset in scope.
`ifndef UTF8_STREAM_DECODER_ASSERT_SVH
`define UTF8_STREAM_DECODER_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define U8D_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("u8d: same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define U8D_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("u8d: next-cycle check failed");

`endif

FILE: src/u8d_pkg.sv
// Shared types and constants for the UTF-8 stream decoder.
// No dependencies.
package u8d_pkg;

   // replacement character and range limits
   localparam logic [20:0] REPL_CP     = 21'h00FFFD;
   localparam logic [20:0] MIN_TWO     = 21'h000080;
   localparam logic [20:0] MIN_THREE   = 21'h000800;
   localparam logic [20:0] MIN_FOUR    = 21'h010000;
   localparam logic [20:0] SURR_LOW    = 21'h00D800;
   localparam logic [20:0] SURR_HIGH   = 21'h00DFFF;
   localparam logic [20:0] MAX_SCALAR  = 21'h10FFFF;

   // byte classes
   localparam logic [7:0] LEAD_LIMIT   = 8'hF8;
   localparam logic [1:0] CONT_TAG     = 2'b10;

   // expected sequence lengths
   localparam logic [2:0] LEN_IDLE     = 3'd0;
   localparam logic [2:0] LEN_TWO      = 3'd2;
   localparam logic [2:0] LEN_THREE    = 3'd3;
   localparam logic [2:0] LEN_FOUR     = 3'd4;

   // command queue sizing
   localparam int QUEUE_DEPTH  = 4;
   localparam int QUEUE_ADDR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_text;
   } u8d_req_type;

   typedef struct packed {
      logic [20:0] code_point;
      logic        is_replacement;
      logic        last_of_run;
   } u8d_rsp_type;

   // at most one command per request: repl_count replacements, then an optional main result
   typedef struct packed {
      logic [2:0]  repl_count;
      logic        main_valid;
      logic [20:0] main_cp;
      logic        main_rep;
   } u8d_cmd_type;

   typedef struct packed {
      logic [1:0] held_count;
      logic [2:0] expected_length;
   } u8d_status_type;

endpackage

FILE: src/u8d_front.sv
// Front end: accepts bytes, tracks held sequence state, emits result commands.
// Depends on u8d_pkg.
module u8d_front
   import u8d_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_push,
   input  u8d_req_type    req_data,
   input  logic           q_full,
   output logic           q_push,
   output u8d_cmd_type    q_cmd,
   output u8d_status_type status
);

   logic [1:0] held_ff, held_in;
   logic [2:0] exp_ff, exp_in;
   logic [7:0] lead_ff, lead_in;
   logic [7:0] cont1_ff, cont1_in;
   logic [7:0] cont2_ff, cont2_in;

   logic        accept;
   logic [7:0]  b;
   logic        is_cont;
   logic        fresh;
   logic [1:0]  broken_n;
   logic [1:0]  after;
   logic        main_valid;
   logic [20:0] main_cp;
   logic        main_rep;
   logic [20:0] fin_cp;
   logic        fin_bad;

   assign accept  = req_push && !q_full;
   assign b       = req_data.in_byte;
   assign is_cont = (b[7:6] == CONT_TAG);

   // assemble the completed scalar and check its range
   always_comb begin
      fin_cp  = REPL_CP;
      fin_bad = 1'b1;
      unique case (exp_ff)
         LEN_TWO: begin
            fin_cp  = {10'd0, lead_ff[4:0], b[5:0]};
            fin_bad = (fin_cp < MIN_TWO);
         end
         LEN_THREE: begin
            fin_cp  = {5'd0, lead_ff[3:0], cont1_ff[5:0], b[5:0]};
            fin_bad = (fin_cp < MIN_THREE) ||
                      ((fin_cp >= SURR_LOW) && (fin_cp <= SURR_HIGH));
         end
         LEN_FOUR: begin
            fin_cp  = {lead_ff[2:0], cont1_ff[5:0], cont2_ff[5:0], b[5:0]};
            fin_bad = (fin_cp < MIN_FOUR) || (fin_cp > MAX_SCALAR);
         end
         default: begin
            fin_cp  = REPL_CP;
            fin_bad = 1'b1;
         end
      endcase
   end

   // classify the byte and work out the next held state
   always_comb begin
      held_in    = held_ff;
      exp_in     = exp_ff;
      lead_in    = lead_ff;
      cont1_in   = cont1_ff;
      cont2_in   = cont2_ff;
      broken_n   = 2'd0;
      after      = 2'd0;
      fresh      = 1'b0;
      main_valid = 1'b0;
      main_cp    = REPL_CP;
      main_rep   = 1'b1;

      if (held_ff != 2'd0) begin
         if (is_cont) begin
            if (({1'b0, held_ff} + 3'd1) >= exp_ff) begin
               main_valid = 1'b1;
               main_cp    = fin_bad ? REPL_CP : fin_cp;
               main_rep   = fin_bad;
               held_in    = 2'd0;
               exp_in     = LEN_IDLE;
            end else begin
               if (held_ff == 2'd1) begin
                  cont1_in = b;
               end else begin
                  cont2_in = b;
               end
               held_in = held_ff + 2'd1;
            end
         end else begin
            // broken sequence: one replacement per held byte, then restart
            broken_n = held_ff;
            held_in  = 2'd0;
            exp_in   = LEN_IDLE;
            fresh    = 1'b1;
         end
      end else begin
         fresh = 1'b1;
      end

      if (fresh) begin
         priority if (!b[7]) begin
            main_valid = 1'b1;
            main_cp    = {13'd0, b};
            main_rep   = 1'b0;
         end else if (is_cont || (b >= LEAD_LIMIT)) begin
            main_valid = 1'b1;
            main_cp    = REPL_CP;
            main_rep   = 1'b1;
         end else begin
            lead_in = b;
            held_in = 2'd1;
            priority if (b[7:5] == 3'b110) begin
               exp_in = LEN_TWO;
            end else if (b[7:4] == 4'b1110) begin
               exp_in = LEN_THREE;
            end else begin
               exp_in = LEN_FOUR;
            end
         end
      end

      // end of text flushes whatever is still held
      if (req_data.end_of_text) begin
         after   = held_in;
         held_in = 2'd0;
         exp_in  = LEN_IDLE;
      end
   end

   always_comb begin
      q_cmd.repl_count = {1'b0, broken_n} + {1'b0, after};
      q_cmd.main_valid = main_valid;
      q_cmd.main_cp    = main_cp;
      q_cmd.main_rep   = main_rep;
      q_push = accept && (main_valid || (q_cmd.repl_count != 3'd0));
   end

   assign status.held_count      = held_ff;
   assign status.expected_length = exp_ff;

   // sequence state
   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= 2'd0;
         exp_ff  <= LEN_IDLE;
      end else if (accept) begin
         held_ff <= held_in;
         exp_ff  <= exp_in;
      end
   end

   // held bytes, no reset needed
   always_ff @(posedge clock) begin
      if (accept) begin
         lead_ff  <= lead_in;
         cont1_ff <= cont1_in;
         cont2_ff <= cont2_in;
      end
   end

endmodule

FILE: src/u8d_queue.sv
// Short command queue between front and back ends.
// Depends on u8d_pkg.
module u8d_queue
   import u8d_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  u8d_cmd_type push_data,
   output logic        full,
   input  logic        pop,
   output u8d_cmd_type pop_data,
   output logic        empty
);

   localparam logic [QUEUE_ADDR_W-1:0] LAST_ADDR = QUEUE_ADDR_W'(QUEUE_DEPTH - 1);
   localparam logic [QUEUE_CNT_W-1:0]  FULL_CNT  = QUEUE_CNT_W'(QUEUE_DEPTH);

   u8d_cmd_type              mem_ff [QUEUE_DEPTH];
   logic [QUEUE_ADDR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_ADDR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]   count_ff, count_in;
   logic                     do_push;
   logic                     do_pop;

   assign full     = (count_ff == FULL_CNT);
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_ADDR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_ADDR) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: src/u8d_back.sv
// Back end: turns commands into output-register results, one per cycle unless stalled.
// Depends on u8d_pkg.
module u8d_back
   import u8d_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  u8d_cmd_type q_cmd,
   input  logic        q_empty,
   output logic        q_pop,
   input  logic        rsp_pop,
   output logic        rsp_empty,
   output u8d_rsp_type rsp_data
);

   logic [2:0]  sent_ff, sent_in;
   logic        valid_ff, valid_in;
   u8d_rsp_type out_ff;
   u8d_rsp_type res;
   logic        can_load;
   logic        emit;
   logic        in_repl;

   assign can_load = !valid_ff || rsp_pop;
   assign emit     = !q_empty && can_load;
   assign in_repl  = (sent_ff < q_cmd.repl_count);

   // pick the next result of the head command
   always_comb begin
      if (in_repl) begin
         res.code_point     = REPL_CP;
         res.is_replacement = 1'b1;
         res.last_of_run    = ((sent_ff + 3'd1) == q_cmd.repl_count) && !q_cmd.main_valid;
      end else begin
         res.code_point     = q_cmd.main_cp;
         res.is_replacement = q_cmd.main_rep;
         res.last_of_run    = 1'b1;
      end
      q_pop = emit && res.last_of_run;

      sent_in = sent_ff;
      if (emit) begin
         sent_in = res.last_of_run ? 3'd0 : sent_ff + 3'd1;
      end

      valid_in = valid_ff;
      if (emit) begin
         valid_in = 1'b1;
      end else if (rsp_pop) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sent_ff  <= 3'd0;
         valid_ff <= 1'b0;
      end else begin
         sent_ff  <= sent_in;
         valid_ff <= valid_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (emit) begin
         out_ff <= res;
      end
   end

   assign rsp_empty = !valid_ff;
   assign rsp_data  = out_ff;

endmodule

FILE: src/utf8_stream_decoder.sv
// UTF-8 stream decoder: one byte in per cycle while not full, one result out per cycle
// unless the output is stalled. Commands pass through the queue and the back end to
// the output register. Input keeps one byte per cycle while each byte gives at most one
// result; a byte with more results holds the back end; a 4-entry queue absorbs bursts.
// Reset (synchronous, active high) clears held state, queue and output valid flag.
`include "utf8_stream_decoder_assert.svh"
module utf8_stream_decoder
   import u8d_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  u8d_req_type req_data,
   output logic        req_full,
   input  logic        rsp_pop,
   output logic        rsp_empty,
   output u8d_rsp_type rsp_data
);

   logic           q_push;
   logic           q_pop;
   logic           q_full;
   logic           q_empty;
   u8d_cmd_type    q_in_cmd;
   u8d_cmd_type    q_out_cmd;
   u8d_status_type front_status;

   assign req_full = q_full;

   u8d_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_data (req_data),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_cmd    (q_in_cmd),
      .status   (front_status)
   );

   u8d_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in_cmd),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_out_cmd),
      .empty     (q_empty)
   );

   u8d_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_cmd     (q_out_cmd),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp_data)
   );

   // checks
   `U8D_ASSERT_SAME(a_repl_value, !rsp_empty && rsp_data.is_replacement, rsp_data.code_point == REPL_CP)
   `U8D_ASSERT_SAME(a_held_below_len, front_status.held_count != 2'd0, front_status.expected_length > {1'b0, front_status.held_count})
   `U8D_ASSERT_NEXT(a_eot_clears, req_push && !req_full && req_data.end_of_text, front_status.held_count == 2'd0)
   `U8D_ASSERT_NEXT(a_queue_filled, q_push, !q_empty)

endmodule
